// ===== src/gwt_pkg.sv =====
`default_nettype none
package gwt_pkg;

  // Field widths
  localparam int CNT_W       = 16;
  localparam int MASK_W      = 3;
  localparam int CH_W        = 2;
  localparam int CFG_IDX_W   = 1;

  // Channel counts
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int OUT_CHANNELS     = 3;

  // rpm = count * 60000 / elapsed_ms
  localparam int MS_PER_SECOND      = 1000;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int RPM_SCALE          = MS_PER_SECOND * SECONDS_PER_MINUTE;
  localparam int PROD_W             = 2 * CNT_W;
  localparam int STEP_W             = $clog2(CNT_W);

  localparam logic [CNT_W-1:0]  CNT_MAX        = '1;
  localparam logic [CNT_W-1:0]  WINDOW_RESET   = CNT_W'(1000);
  localparam logic [MASK_W-1:0] RAW_MASK_RESET = MASK_W'(1);

  // Request kinds
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_PULSE = 1'b1
  } req_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MS = 1'b0,
    REG_RAW_MODE  = 1'b1
  } cfg_reg_t;

  // Window close sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Shared divider phases
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_ITER,
    DIV_DONE
  } div_phase_t;

endpackage
`default_nettype wire

// ===== src/gwt_div.sv =====
`default_nettype none
// Iterative rpm unit: one multiply, a saturation check, then one quotient
// bit per cycle of restoring division.
module gwt_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [gwt_pkg::CNT_W-1:0] count,
  input  wire logic [gwt_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [gwt_pkg::CNT_W-1:0]      quotient,
  output logic                           sat
);

  gwt_pkg::div_phase_t phase, phase_next;

  logic [gwt_pkg::PROD_W-1:0] prod;
  logic [gwt_pkg::CNT_W-1:0]  rem;
  logic [gwt_pkg::CNT_W-1:0]  quo;
  logic [gwt_pkg::STEP_W-1:0] step;
  logic                       sat_r;

  logic                       over;
  logic [gwt_pkg::CNT_W:0]    trial;
  logic                       fits;
  logic                       last_step;

  // Quotient exceeds 16 bits when the high half of the product >= divisor
  assign over      = (prod[gwt_pkg::PROD_W-1:gwt_pkg::CNT_W] >= divisor);
  assign trial     = {rem, quo[gwt_pkg::CNT_W-1]};
  assign fits      = (trial >= {1'b0, divisor});
  assign last_step = (step == gwt_pkg::STEP_W'(gwt_pkg::CNT_W - 1));

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      gwt_pkg::DIV_IDLE:  if (start) phase_next = gwt_pkg::DIV_CHECK;
      gwt_pkg::DIV_CHECK: phase_next = over ? gwt_pkg::DIV_DONE : gwt_pkg::DIV_ITER;
      gwt_pkg::DIV_ITER:  if (last_step) phase_next = gwt_pkg::DIV_DONE;
      gwt_pkg::DIV_DONE:  phase_next = gwt_pkg::DIV_IDLE;
      default:            phase_next = gwt_pkg::DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done     = (phase == gwt_pkg::DIV_DONE);
    quotient = quo;
    sat      = sat_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= gwt_pkg::DIV_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (phase)
      gwt_pkg::DIV_IDLE: begin
        if (start) begin
          prod <= {{gwt_pkg::CNT_W{1'b0}}, count} *
                  gwt_pkg::PROD_W'(gwt_pkg::RPM_SCALE);
        end
      end
      gwt_pkg::DIV_CHECK: begin
        step <= '0;
        if (over) begin
          quo   <= gwt_pkg::CNT_MAX;
          sat_r <= 1'b1;
        end else begin
          rem   <= prod[gwt_pkg::PROD_W-1:gwt_pkg::CNT_W];
          quo   <= prod[gwt_pkg::CNT_W-1:0];
          sat_r <= 1'b0;
        end
      end
      gwt_pkg::DIV_ITER: begin
        step <= step + 1'b1;
        if (fits) begin
          rem <= gwt_pkg::CNT_W'(trial - {1'b0, divisor});
          quo <= {quo[gwt_pkg::CNT_W-2:0], 1'b1};
        end else begin
          rem <= trial[gwt_pkg::CNT_W-1:0];
          quo <= {quo[gwt_pkg::CNT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/gated_window_tachometer.sv =====
// Requests are accepted back to back while no close is in progress. A tick that
// closes the window stalls input for the close: each channel in turn is recorded
// raw, as zero if absent, or as rpm from the shared divider (multiply, saturation
// check, 16 quotient bits, skipped when it saturates), then the output is loaded,
// waiting while a stalled result holds it. A pending result does not block input.
// Synchronous reset clears counters, sets window 1000 ms and channel 0 to raw.
`default_nettype none
module gated_window_tachometer #(
  parameter int NUM_CHANNELS = gwt_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [gwt_pkg::CH_W-1:0]      channel,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [gwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gwt_pkg::CNT_W-1:0]     cfg_data,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gwt_pkg::CNT_W-1:0]          value_ch0,
  output logic [gwt_pkg::CNT_W-1:0]          value_ch1,
  output logic [gwt_pkg::CNT_W-1:0]          value_ch2,
  output logic [gwt_pkg::CNT_W-1:0]          elapsed_ticks,
  output logic [gwt_pkg::MASK_W-1:0]         sat_flags
);

  localparam int OC = gwt_pkg::OUT_CHANNELS;

  gwt_pkg::state_t state, state_next;

  logic [gwt_pkg::CNT_W-1:0]  window_ms;
  logic [gwt_pkg::MASK_W-1:0] raw_mode_mask;

  logic [gwt_pkg::CNT_W-1:0] cnt [NUM_CHANNELS];
  logic [gwt_pkg::CNT_W-1:0] elapsed;
  logic [gwt_pkg::CNT_W-1:0] elapsed_inc;

  logic [gwt_pkg::CNT_W-1:0] snap [OC];
  logic [gwt_pkg::CNT_W-1:0] snap_elapsed;
  logic [gwt_pkg::CNT_W-1:0] res_val [OC];
  logic [OC-1:0]             res_sat;
  logic [gwt_pkg::CH_W-1:0]  ch_idx;

  logic accept;
  logic is_tick;
  logic close;
  logic chan_absent;
  logic chan_raw;
  logic chan_last;

  logic                      div_start;
  logic                      div_done;
  logic [gwt_pkg::CNT_W-1:0] div_q;
  logic                      div_sat;

  logic                      rec_en;
  logic [gwt_pkg::CNT_W-1:0] rec_val;
  logic                      rec_sat;
  logic                      emit_load;

  assign accept      = in_valid && !in_stall;
  assign is_tick     = (req_type == gwt_pkg::REQ_TICK);
  assign elapsed_inc = elapsed + 1'b1;
  assign close       = accept && is_tick &&
                       ((elapsed_inc > window_ms) || (elapsed_inc == gwt_pkg::CNT_MAX));

  assign chan_absent = (32'(ch_idx) >= NUM_CHANNELS);
  assign chan_raw    = raw_mode_mask[ch_idx];
  assign chan_last   = (ch_idx == gwt_pkg::CH_W'(OC - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms     <= gwt_pkg::WINDOW_RESET;
      raw_mode_mask <= gwt_pkg::RAW_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gwt_pkg::REG_WINDOW_MS: window_ms     <= cfg_data;
        gwt_pkg::REG_RAW_MODE:  raw_mode_mask <= cfg_data[gwt_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pulse counters and elapsed time; cleared when the window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) cnt[i] <= '0;
    end else if (close) begin
      elapsed <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) cnt[i] <= '0;
    end else if (accept) begin
      if (is_tick) begin
        elapsed <= elapsed_inc;
      end else begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (32'(channel) == i) cnt[i] <= cnt[i] + 1'b1;
        end
      end
    end
  end

  // Snapshot of the closing window
  always_ff @(posedge clk) begin
    if (close) begin
      snap_elapsed <= elapsed_inc;
      for (int j = 0; j < OC; j++) begin
        snap[j] <= (j < NUM_CHANNELS) ? cnt[j] : '0;
      end
    end
  end

  // Shared rpm divider
  gwt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .count    (snap[ch_idx]),
    .divisor  (snap_elapsed),
    .done     (div_done),
    .quotient (div_q),
    .sat      (div_sat)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      gwt_pkg::ST_IDLE: if (close) state_next = gwt_pkg::ST_CHAN;
      gwt_pkg::ST_CHAN: begin
        if (!chan_absent && !chan_raw) state_next = gwt_pkg::ST_WAIT;
        else if (chan_last)            state_next = gwt_pkg::ST_EMIT;
      end
      gwt_pkg::ST_WAIT: begin
        if (div_done) state_next = chan_last ? gwt_pkg::ST_EMIT : gwt_pkg::ST_CHAN;
      end
      gwt_pkg::ST_EMIT: if (!out_valid || !out_stall) state_next = gwt_pkg::ST_IDLE;
      default:          state_next = gwt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = (state != gwt_pkg::ST_IDLE);
    div_start = 1'b0;
    rec_en    = 1'b0;
    rec_val   = '0;
    rec_sat   = 1'b0;
    emit_load = 1'b0;
    case (state)
      gwt_pkg::ST_CHAN: begin
        if (chan_absent) begin
          rec_en = 1'b1;
        end else if (chan_raw) begin
          rec_en  = 1'b1;
          rec_val = snap[ch_idx];
        end else begin
          div_start = 1'b1;
        end
      end
      gwt_pkg::ST_WAIT: begin
        rec_en  = div_done;
        rec_val = div_q;
        rec_sat = div_sat;
      end
      gwt_pkg::ST_EMIT: emit_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Channel walk and per-channel results
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx <= '0;
    end else if (close) begin
      ch_idx <= '0;
    end else if (rec_en) begin
      ch_idx <= chan_last ? '0 : ch_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_en) begin
      res_val[ch_idx] <= rec_val;
      res_sat[ch_idx] <= rec_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      value_ch0     <= res_val[0];
      value_ch1     <= res_val[1];
      value_ch2     <= res_val[2];
      elapsed_ticks <= snap_elapsed;
      sat_flags     <= gwt_pkg::MASK_W'(res_sat);
    end
  end

endmodule
`default_nettype wire
